// ===== hw/rtl/mbet_pkg.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, configuration register map and the request and response
// types of the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mbet_pkg;

    // Number format: signed fixed point with FRAC_BITS fraction bits.
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 44;
    localparam int ITER_BITS  = 16;

    localparam int WORD_W  = FRAC_BITS + 4;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int HALF_W  = (WORD_W + 1) / 2;
    localparam int MAG_W   = 2 * HALF_W;
    localparam int ACC_W   = 2 * MAG_W;
    localparam int ESC_BIT = 2 * FRAC_BITS + 2;

    // Configuration register widths.
    localparam int MIN_W     = 48;
    localparam int STEP_W    = 47;
    localparam int MAXIT_W   = 16;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;

    // Register values after reset.
    localparam logic [MIN_W-1:0]   MIN_REAL_RST = 48'hE000_0000_0000;
    localparam logic [MIN_W-1:0]   MIN_IMAG_RST = 48'hE800_0000_0000;
    localparam logic [STEP_W-1:0]  STEP_RST     = 47'd54975581388;
    localparam logic [MAXIT_W-1:0] MAXIT_RST    = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_REAL   = 3'd0,
        REG_MIN_IMAG   = 3'd1,
        REG_STEP_REAL  = 3'd2,
        REG_STEP_IMAG  = 3'd3,
        REG_ITER_LIMIT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [MIN_W-1:0]   min_real;
        logic [MIN_W-1:0]   min_imag;
        logic [STEP_W-1:0]  step_real;
        logic [STEP_W-1:0]  step_imag;
        logic [MAXIT_W-1:0] iter_limit;
    } t_cfg;

    typedef struct packed {
        logic                     start;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } t_mul_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/mbet_pix_if.sv =====
// ----------------------------------------------------------------------------
// Pixel channel
// Carries one pixel coordinate word with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbet_pix_if;
    import mbet_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;

    modport source (output valid, output col, output row, input ready);
    modport sink   (input valid, input col, input row, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mbet_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Carries one iteration count word and its pixel coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbet_res_if;
    import mbet_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MAXIT_W-1:0]    iterations;
    logic [COORD_BITS-1:0] out_col;
    logic [COORD_BITS-1:0] out_row;

    modport source (output valid, output iterations, output out_col, output out_row,
                    input ready);
    modport sink   (input valid, input iterations, input out_col, input out_row,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mbet_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the view window, the pixel steps and the iteration limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mbet_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [mbet_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [mbet_pkg::CFG_W-1:0]   i_data,
    output mbet_pkg::t_cfg               o_cfg
);
    import mbet_pkg::*;

    logic [MIN_W-1:0]   r_min_real;
    logic [MIN_W-1:0]   r_min_imag;
    logic [STEP_W-1:0]  r_step_real;
    logic [STEP_W-1:0]  r_step_imag;
    logic [MAXIT_W-1:0] r_iter_limit;

    // Register writes; bits above a register's width are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_real   <= MIN_REAL_RST;
            r_min_imag   <= MIN_IMAG_RST;
            r_step_real  <= STEP_RST;
            r_step_imag  <= STEP_RST;
            r_iter_limit <= MAXIT_RST;
        end else if (i_we) begin
            unique case (t_reg_idx'(i_idx))
                REG_MIN_REAL:   r_min_real   <= i_data[MIN_W-1:0];
                REG_MIN_IMAG:   r_min_imag   <= i_data[MIN_W-1:0];
                REG_STEP_REAL:  r_step_real  <= i_data[STEP_W-1:0];
                REG_STEP_IMAG:  r_step_imag  <= i_data[STEP_W-1:0];
                REG_ITER_LIMIT: r_iter_limit <= i_data[MAXIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.min_real   = r_min_real;
    assign o_cfg.min_imag   = r_min_imag;
    assign o_cfg.step_real  = r_step_real;
    assign o_cfg.step_imag  = r_step_imag;
    assign o_cfg.iter_limit = r_iter_limit;

endmodule

`default_nettype wire

// ===== hw/rtl/mbet_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed word by word product built from four half-width partial products,
// one per cycle, followed by a sign fix-up step.
// ----------------------------------------------------------------------------
`default_nettype none

module mbet_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbet_pkg::t_mul_req i_req,
    output mbet_pkg::t_mul_rsp o_rsp
);
    import mbet_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_SIGN = 3'b100
    } t_mul_state;

    t_mul_state          r_state;
    t_mul_state          n_state;
    logic [MAG_W-1:0]    r_am;
    logic [MAG_W-1:0]    r_bm;
    logic                r_neg;
    logic [1:0]          r_idx;
    logic [ACC_W-1:0]    r_acc;
    logic                r_done;

    logic [WORD_W-1:0]   a_abs;
    logic [WORD_W-1:0]   b_abs;
    logic [HALF_W-1:0]   a_part;
    logic [HALF_W-1:0]   b_part;
    logic [2*HALF_W-1:0] pp;
    logic [ACC_W-1:0]    pp_sh;

    // Operand magnitudes; the most negative word maps to its exact magnitude.
    assign a_abs = i_req.a[WORD_W-1] ? (~i_req.a + 1'b1) : i_req.a;
    assign b_abs = i_req.b[WORD_W-1] ? (~i_req.b + 1'b1) : i_req.b;

    // Low bit of the index picks the half of a, high bit the half of b.
    assign a_part = r_idx[0] ? r_am[MAG_W-1:HALF_W] : r_am[HALF_W-1:0];
    assign b_part = r_idx[1] ? r_bm[MAG_W-1:HALF_W] : r_bm[HALF_W-1:0];
    assign pp     = a_part * b_part;

    // Align the partial product to its weight.
    always_comb begin
        case (r_idx) inside
            2'b00:        pp_sh = ACC_W'(pp);
            2'b01, 2'b10: pp_sh = ACC_W'(pp) << HALF_W;
            default:      pp_sh = ACC_W'(pp) << (2 * HALF_W);
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE:  if (i_req.start) n_state = M_RUN;
            M_RUN:   if (&r_idx) n_state = M_SIGN;
            M_SIGN:  n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_SIGN);
        end
    end

    // Accumulator and operand registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    r_am  <= MAG_W'(a_abs);
                    r_bm  <= MAG_W'(b_abs);
                    r_neg <= i_req.a[WORD_W-1] ^ i_req.b[WORD_W-1];
                    r_acc <= '0;
                    r_idx <= '0;
                end
            end
            M_RUN: begin
                r_acc <= r_acc + pp_sh;
                r_idx <= r_idx + 1'b1;
            end
            M_SIGN: begin
                if (r_neg) r_acc <= ~r_acc + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc[PROD_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time engine
// Counts iterations of z = z*z + c for one pixel at a time.
// ----------------------------------------------------------------------------
// The block takes one pixel word (col, row) when it is idle, forms
// c = (min_real + col*step_real, min_imag + row*step_imag) with saturation,
// and iterates z = z*z + c from z = c until |z|^2 reaches 4.0 or the iteration
// limit of steps has run. It returns the step count with the pixel coordinate.
// All products run through one shared multiplier that works on one 48 by 48
// bit product at a time: forming c takes two products, and each step takes
// three products, the escape test and the update. Input ready is high only
// while no pixel is in progress. The result sits in an output register, so
// the next pixel may start while the previous count waits to be taken.
// Configuration writes take effect at once and belong between pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mbet_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mbet_pkg::CFG_W-1:0]     i_cfg_data,
    mbet_pix_if.sink                       i_pix,
    mbet_res_if.source                     o_res
);
    import mbet_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_CRE  = 10'b00_0000_0010,
        S_CIM  = 10'b00_0000_0100,
        S_CHK  = 10'b00_0000_1000,
        S_MR2  = 10'b00_0001_0000,
        S_MI2  = 10'b00_0010_0000,
        S_MRI  = 10'b00_0100_0000,
        S_UPD1 = 10'b00_1000_0000,
        S_UPD2 = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

    // Clamp a wide signed value to the word range.
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
        logic                     ovf;
        logic signed [WORD_W-1:0] res;
        ovf = (v[PROD_W-1:WORD_W-1] != {(PROD_W-WORD_W+1){v[PROD_W-1]}});
        if (!ovf) begin
            res = v[WORD_W-1:0];
        end else if (v[PROD_W-1]) begin
            res = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    t_cfg     cfg;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    t_state                   r_state;
    t_state                   n_state;
    logic [COORD_BITS-1:0]    r_col;
    logic [COORD_BITS-1:0]    r_row;
    logic [ITER_BITS-1:0]     r_limit;
    logic [ITER_BITS-1:0]     r_count;
    logic signed [WORD_W-1:0] r_cr;
    logic signed [WORD_W-1:0] r_ci;
    logic signed [WORD_W-1:0] r_zr;
    logic signed [WORD_W-1:0] r_zi;
    logic signed [PROD_W-1:0] r_r2;
    logic signed [PROD_W-1:0] r_i2;
    logic signed [PROD_W-1:0] r_ri;
    logic                     r_out_valid;
    logic [MAXIT_W-1:0]       r_out_iter;
    logic [COORD_BITS-1:0]    r_out_col;
    logic [COORD_BITS-1:0]    r_out_row;

    logic                     pix_acc;
    logic                     out_load;
    logic                     escape;
    logic [MIN_W-1:0]         base;
    logic signed [PROD_W-1:0] coord_sum;
    logic signed [WORD_W-1:0] c_sat;
    logic [PROD_W-1:0]        sum_sq;
    logic signed [PROD_W-1:0] sq_diff;
    logic signed [PROD_W-1:0] zr_shr;
    logic signed [PROD_W-1:0] zi_shr;
    logic signed [PROD_W-1:0] zr_sum;
    logic signed [PROD_W-1:0] zi_sum;

    mbet_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    mbet_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Handshakes.
    assign i_pix.ready = (r_state == S_IDLE);
    assign pix_acc     = i_pix.valid && (r_state == S_IDLE);
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    // Start point: window origin plus index times step, clamped.
    assign base      = (r_state == S_CRE) ? cfg.min_real : cfg.min_imag;
    assign coord_sum = {{(PROD_W-MIN_W){base[MIN_W-1]}}, base} + mul_rsp.prod;
    assign c_sat     = sat_word(coord_sum);

    // Escape test on the exact sum of squares, and the real-part difference.
    assign sum_sq  = r_r2 + r_i2;
    assign escape  = |sum_sq[PROD_W-1:ESC_BIT];
    assign sq_diff = r_r2 - r_i2;

    // New z: floor to the word scale, add c. Twice zr*zi is one shift less.
    assign zr_shr = r_r2 >>> FRAC_BITS;
    assign zi_shr = r_ri >>> (FRAC_BITS - 1);
    assign zr_sum = zr_shr + {{(PROD_W-WORD_W){r_cr[WORD_W-1]}}, r_cr};
    assign zi_sum = zi_shr + {{(PROD_W-WORD_W){r_ci[WORD_W-1]}}, r_ci};

    // Sequencer and multiplier requests.
    always_comb begin
        n_state       = r_state;
        mul_req.start = 1'b0;
        mul_req.a     = r_zr;
        mul_req.b     = r_zi;
        unique case (r_state)
            S_IDLE: begin
                if (pix_acc) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = WORD_W'({1'b0, cfg.step_real});
                    mul_req.b     = WORD_W'(i_pix.col);
                    n_state       = S_CRE;
                end
            end
            S_CRE: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = WORD_W'({1'b0, cfg.step_imag});
                    mul_req.b     = WORD_W'(r_row);
                    n_state       = S_CIM;
                end
            end
            S_CIM: begin
                if (mul_rsp.done) n_state = S_CHK;
            end
            S_CHK: begin
                if (r_count < r_limit) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = r_zr;
                    mul_req.b     = r_zr;
                    n_state       = S_MR2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MR2: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = r_zi;
                    mul_req.b     = r_zi;
                    n_state       = S_MI2;
                end
            end
            S_MI2: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = r_zr;
                    mul_req.b     = r_zi;
                    n_state       = S_MRI;
                end
            end
            S_MRI: begin
                if (mul_rsp.done) n_state = S_UPD1;
            end
            S_UPD1: n_state = escape ? S_DONE : S_UPD2;
            S_UPD2: n_state = S_CHK;
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Iteration datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (pix_acc) begin
                    r_col   <= i_pix.col;
                    r_row   <= i_pix.row;
                    r_limit <= ITER_BITS'(cfg.iter_limit);
                    r_count <= '0;
                end
            end
            S_CRE: begin
                if (mul_rsp.done) r_cr <= c_sat;
            end
            S_CIM: begin
                if (mul_rsp.done) begin
                    r_ci <= c_sat;
                    r_zr <= r_cr;
                    r_zi <= c_sat;
                end
            end
            S_MR2: begin
                if (mul_rsp.done) r_r2 <= mul_rsp.prod;
            end
            S_MI2: begin
                if (mul_rsp.done) r_i2 <= mul_rsp.prod;
            end
            S_MRI: begin
                if (mul_rsp.done) r_ri <= mul_rsp.prod;
            end
            S_UPD1: begin
                r_r2 <= sq_diff;
            end
            S_UPD2: begin
                r_zr    <= sat_word(zr_sum);
                r_zi    <= sat_word(zi_sum);
                r_count <= r_count + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_iter <= MAXIT_W'(r_count);
            r_out_col  <= r_col;
            r_out_row  <= r_row;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.iterations = r_out_iter;
    assign o_res.out_col    = r_out_col;
    assign o_res.out_row    = r_out_row;

endmodule

`default_nettype wire

// ===== hw/rtl/mbet_chk.sv =====
// ----------------------------------------------------------------------------
// Escape-time port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module mbet_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mbet_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [mbet_pkg::MAXIT_W-1:0]      i_iterations,
    input  logic [mbet_pkg::COORD_BITS-1:0]   i_out_col,
    input  logic [mbet_pkg::COORD_BITS-1:0]   i_out_row
);
    import mbet_pkg::*;

    logic [MAXIT_W-1:0] r_iter_limit;

    // Shadow of the iteration limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter_limit <= MAXIT_RST;
        end else if (i_cfg_we && (i_cfg_idx == REG_ITER_LIMIT)) begin
            r_iter_limit <= i_cfg_data[MAXIT_W-1:0];
        end
    end

    // A waiting result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result word dropped before it was taken");

    // A waiting result word does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_iterations) && $stable(i_out_col) && $stable(i_out_row)))
        else $error("result word changed while stalled");

    // One pixel at a time: ready drops right after a pixel is taken.
    a_one_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second pixel taken while one is in progress");

    // A count never exceeds the iteration limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_iterations <= r_iter_limit))
        else $error("iteration count above the limit");

endmodule

bind mandelbrot_escape_time mbet_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_idx    (i_cfg_idx),
    .i_cfg_data   (i_cfg_data),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_iterations (o_res.iterations),
    .i_out_col    (o_res.out_col),
    .i_out_row    (o_res.out_row)
);

`default_nettype wire
